// ===== sv/ssod_pkg.sv =====
// ssod_pkg: shared types and constants for the scan sector obstacle detector
// holds register indexes, field widths and the configuration struct
// no dependencies
package ssod_pkg;

    // saturation limit of the obstacle point count
    localparam int MAX_POINTS = 4096;

    localparam int ANGLE_W = 24;
    localparam int ACC_W   = 32;
    localparam int DIST_W  = 16;
    localparam int COUNT_W = 13;
    localparam int DEC_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_START_ANGLE     = 3'd0,
        REG_ANGLE_STEP      = 3'd1,
        REG_ANGLE_LOW       = 3'd2,
        REG_ANGLE_HIGH      = 3'd3,
        REG_DISTANCE_LOW    = 3'd4,
        REG_DISTANCE_HIGH   = 3'd5,
        REG_COUNT_THRESHOLD = 3'd6,
        REG_SCAN_DECIMATION = 3'd7
    } ssod_reg_idx_t;

    // register reset values
    localparam logic [ANGLE_W-1:0] START_ANGLE_RST     = 24'hFCDBC1; // -205887
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST      = 24'd1144;
    localparam logic [ANGLE_W-1:0] ANGLE_LOW_RST       = 24'hFF4000; // -49152
    localparam logic [ANGLE_W-1:0] ANGLE_HIGH_RST      = 24'd49152;
    localparam logic [DIST_W-1:0]  DISTANCE_LOW_RST    = 16'd100;
    localparam logic [DIST_W-1:0]  DISTANCE_HIGH_RST   = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_THRESHOLD_RST = 13'd50;
    localparam logic [DEC_W-1:0]   SCAN_DECIMATION_RST = 8'd2;

    // configuration seen by the datapath
    typedef struct packed {
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
        logic [ANGLE_W-1:0] angle_low;
        logic [ANGLE_W-1:0] angle_high;
        logic [DIST_W-1:0]  distance_low;
        logic [DIST_W-1:0]  distance_high;
        logic [COUNT_W-1:0] count_threshold;
        logic [DEC_W-1:0]   scan_decimation;
    } ssod_cfg_t;

    // result of one processed sample
    typedef struct packed {
        logic               emit;
        logic               obstacle;
        logic [COUNT_W-1:0] count;
    } ssod_res_t;

endpackage

// ===== sv/ssod_regs.sv =====
// ssod_regs: configuration register file behind the APB-style port
// depends on ssod_pkg for register indexes, widths and reset values
module ssod_regs
    import ssod_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output ssod_cfg_t         cfg
);

    ssod_cfg_t     cfg_reg;
    ssod_reg_idx_t wr_idx;
    logic          wr_en;

    assign wr_idx = ssod_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes, truncated to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle     <= START_ANGLE_RST;
            cfg_reg.angle_step      <= ANGLE_STEP_RST;
            cfg_reg.angle_low       <= ANGLE_LOW_RST;
            cfg_reg.angle_high      <= ANGLE_HIGH_RST;
            cfg_reg.distance_low    <= DISTANCE_LOW_RST;
            cfg_reg.distance_high   <= DISTANCE_HIGH_RST;
            cfg_reg.count_threshold <= COUNT_THRESHOLD_RST;
            cfg_reg.scan_decimation <= SCAN_DECIMATION_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_START_ANGLE:     cfg_reg.start_angle     <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_STEP:      cfg_reg.angle_step      <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_LOW:       cfg_reg.angle_low       <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_HIGH:      cfg_reg.angle_high      <= pwdata[ANGLE_W-1:0];
                REG_DISTANCE_LOW:    cfg_reg.distance_low    <= pwdata[DIST_W-1:0];
                REG_DISTANCE_HIGH:   cfg_reg.distance_high   <= pwdata[DIST_W-1:0];
                REG_COUNT_THRESHOLD: cfg_reg.count_threshold <= pwdata[COUNT_W-1:0];
                REG_SCAN_DECIMATION: cfg_reg.scan_decimation <= pwdata[DEC_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // read mux, angles sign extended
    always_comb
    begin
        unique case (wr_idx)
            REG_START_ANGLE:     prdata = DATA_W'($signed(cfg_reg.start_angle));
            REG_ANGLE_STEP:      prdata = DATA_W'($signed(cfg_reg.angle_step));
            REG_ANGLE_LOW:       prdata = DATA_W'($signed(cfg_reg.angle_low));
            REG_ANGLE_HIGH:      prdata = DATA_W'($signed(cfg_reg.angle_high));
            REG_DISTANCE_LOW:    prdata = DATA_W'(cfg_reg.distance_low);
            REG_DISTANCE_HIGH:   prdata = DATA_W'(cfg_reg.distance_high);
            REG_COUNT_THRESHOLD: prdata = DATA_W'(cfg_reg.count_threshold);
            REG_SCAN_DECIMATION: prdata = DATA_W'(cfg_reg.scan_decimation);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== sv/ssod_core.sv =====
// ssod_core: per-sample scan state, angle accumulation and point counting
// depends on ssod_pkg for the configuration and result structs
module ssod_core
    import ssod_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ssod_cfg_t         cfg,
    input  logic              step,
    input  logic [DIST_W-1:0] distance,
    input  logic              last,
    output ssod_res_t         res
);

    logic [DEC_W-1:0]          scan_counter_reg, scan_counter_next;
    logic                      scan_examined_reg, scan_examined_next;
    logic                      at_scan_start_reg, at_scan_start_next;
    logic signed [ACC_W-1:0]   angle_acc_reg, angle_acc_next;
    logic [COUNT_W-1:0]        count_reg, count_next;

    logic [DEC_W:0]            counter_inc;
    logic                      examine_new;
    logic signed [ACC_W:0]     angle_sum;
    logic signed [ACC_W-1:0]   angle_cur;
    logic                      examined_cur;
    logic [COUNT_W-1:0]        count_base;
    logic [COUNT_W-1:0]        count_cur;
    logic                      hit;

    // scan start decision: wraps when the counter reaches the decimation
    assign counter_inc = {1'b0, scan_counter_reg} + {{DEC_W{1'b0}}, 1'b1};
    assign examine_new = counter_inc >= {1'b0, cfg.scan_decimation};

    // saturating angle accumulation
    assign angle_sum = {angle_acc_reg[ACC_W-1], angle_acc_reg}
                     + (ACC_W+1)'($signed(cfg.angle_step));

    always_comb
    begin
        scan_counter_next = scan_counter_reg;
        if (at_scan_start_reg)
        begin
            angle_cur    = ACC_W'($signed(cfg.start_angle));
            examined_cur = examine_new;
            count_base   = '0;
            scan_counter_next = examine_new ? '0 : counter_inc[DEC_W-1:0];
        end
        else
        begin
            examined_cur = scan_examined_reg;
            count_base   = count_reg;
            if (angle_sum[ACC_W] != angle_sum[ACC_W-1])
                angle_cur = angle_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : {1'b0, {(ACC_W-1){1'b1}}};
            else
                angle_cur = angle_sum[ACC_W-1:0];
        end
    end

    // window test and saturating count
    assign hit = examined_cur
              && (angle_cur >= ACC_W'($signed(cfg.angle_low)))
              && (angle_cur <= ACC_W'($signed(cfg.angle_high)))
              && (distance >= cfg.distance_low)
              && (distance <= cfg.distance_high);

    assign count_cur = (hit && (count_base < COUNT_W'(MAX_POINTS)))
                     ? count_base + {{(COUNT_W-1){1'b0}}, 1'b1}
                     : count_base;

    assign scan_examined_next = examined_cur;
    assign at_scan_start_next = last;
    assign angle_acc_next     = angle_cur;
    assign count_next         = last ? '0 : count_cur;

    assign res.emit     = step && last && examined_cur;
    assign res.obstacle = count_cur > cfg.count_threshold;
    assign res.count    = count_cur;

    // scan state update on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_counter_reg  <= '0;
            scan_examined_reg <= 1'b0;
            at_scan_start_reg <= 1'b1;
            angle_acc_reg     <= '0;
            count_reg         <= '0;
        end
        else if (step)
        begin
            scan_counter_reg  <= scan_counter_next;
            scan_examined_reg <= scan_examined_next;
            at_scan_start_reg <= at_scan_start_next;
            angle_acc_reg     <= angle_acc_next;
            count_reg         <= count_next;
        end
    end

endmodule

// ===== sv/scan_sector_obstacle_detector.sv =====
// Scan sector obstacle detector.
// Sample channel: sample_valid/sample_ready carry distance_mm and
// last_of_scan, one range sample per transfer. Result channel:
// result_valid/result_ready carry obstacle_present and point_count, one
// transfer at the end of every examined scan; skipped scans give none.
// Configuration is written over the APB-style port (register i at byte
// address 4*i); the user must write it only while no sample is in flight;
// the block does not enforce this. A sample waits in the input register
// and is processed from there; its result goes into the result register.
// Throughput: one sample per cycle unless stalled, set by the single pass
// through the angle adder, window compares and count increment.
// When the receiver stalls, the result register holds; one more sample is
// taken into the input register, then sample_ready drops until the result
// is taken.
// Reset clears the scan state and the pipeline and loads the register
// defaults; the first sample after reset starts a new scan.
// depends on ssod_pkg, ssod_regs and ssod_core
module scan_sector_obstacle_detector
    import ssod_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic [DIST_W-1:0]  distance_mm,
    input  logic               last_of_scan,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               obstacle_present,
    output logic [COUNT_W-1:0] point_count
);

    ssod_cfg_t          cfg;
    ssod_res_t          res;
    logic               step;

    logic               samp_valid_reg;
    logic [DIST_W-1:0]  samp_dist_reg;
    logic               samp_last_reg;

    logic               res_valid_reg;
    logic               res_obstacle_reg;
    logic [COUNT_W-1:0] res_count_reg;

    assign pready = 1'b1;

    ssod_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // process a held sample unless a result is still waiting
    assign step         = samp_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !samp_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            samp_valid_reg <= 1'b0;
        else if (sample_ready)
            samp_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            samp_dist_reg <= distance_mm;
            samp_last_reg <= last_of_scan;
        end
    end

    ssod_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .step     (step),
        .distance (samp_dist_reg),
        .last     (samp_last_reg),
        .res      (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res.emit)
            res_valid_reg <= 1'b1;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            res_obstacle_reg <= res.obstacle;
            res_count_reg    <= res.count;
        end
    end

    assign result_valid     = res_valid_reg;
    assign obstacle_present = res_obstacle_reg;
    assign point_count      = res_count_reg;

endmodule

// ===== sv/ssod_checker.sv =====
// ssod_checker: port-level checks on the scan sector obstacle detector
// depends on ssod_pkg; bound to scan_sector_obstacle_detector below
module ssod_checker
    import ssod_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               result_valid,
    input logic               result_ready,
    input logic               obstacle_present,
    input logic [COUNT_W-1:0] point_count
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(point_count) && $stable(obstacle_present))
        else $error("result changed while stalled");

    // count never passes the saturation limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> point_count <= COUNT_W'(MAX_POINTS))
        else $error("point count above limit");

    // an obstacle needs at least one point
    a_obstacle_points: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && obstacle_present |-> point_count != '0)
        else $error("obstacle flagged with no points");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind scan_sector_obstacle_detector ssod_checker u_ssod_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pready           (pready),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .obstacle_present (obstacle_present),
    .point_count      (point_count)
);

// ===== verif/scan_report_checker.sv =====
`timescale 1ns / 1ps
// scan_report_checker: watches the configuration port and both streams of the detector
// keeps its own scan tracker, predicts each scan report and compares it; uses ssod_pkg
module scan_report_checker
    import ssod_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               sample_valid,
    input  logic               sample_ready,
    input  logic [DIST_W-1:0]  distance_mm,
    input  logic               last_of_scan,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic               obstacle_present,
    input  logic [COUNT_W-1:0] point_count,
    output int                 mismatches,
    output int                 outstanding,
    output int                 reports_seen
);

    typedef struct packed {
        logic               obstacle;
        logic [COUNT_W-1:0] count;
    } scan_report_t;

    // the accumulator saturates at the signed 32-bit limits
    localparam logic signed [33:0] BEARING_MAX = 34'sd2147483647;
    localparam logic signed [33:0] BEARING_MIN = -34'sd2147483648;

    ssod_cfg_t                 cfg;
    logic [DEC_W-1:0]          scan_cnt;
    logic                      examined;
    logic                      at_start;
    logic signed [ACC_W-1:0]   bearing;
    logic [COUNT_W-1:0]        hits;
    scan_report_t              expected_reports[$];
    scan_report_t              oldest;

    function automatic logic signed [33:0] widen_angle(input logic [ANGLE_W-1:0] v);
        return {{(34-ANGLE_W){v[ANGLE_W-1]}}, v};
    endfunction

    // register update as the port writes it, masked to the register width
    task automatic apply_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        case (ssod_reg_idx_t'(idx))
            REG_START_ANGLE:     cfg.start_angle     = data[ANGLE_W-1:0];
            REG_ANGLE_STEP:      cfg.angle_step      = data[ANGLE_W-1:0];
            REG_ANGLE_LOW:       cfg.angle_low       = data[ANGLE_W-1:0];
            REG_ANGLE_HIGH:      cfg.angle_high      = data[ANGLE_W-1:0];
            REG_DISTANCE_LOW:    cfg.distance_low    = data[DIST_W-1:0];
            REG_DISTANCE_HIGH:   cfg.distance_high   = data[DIST_W-1:0];
            REG_COUNT_THRESHOLD: cfg.count_threshold = data[COUNT_W-1:0];
            REG_SCAN_DECIMATION: cfg.scan_decimation = data[DEC_W-1:0];
            default: ;
        endcase
    endtask

    // one sample through the tracker; queues a report at the end of an examined scan
    task automatic track_sample(input logic [DIST_W-1:0] range_mm, input logic last);
        logic signed [33:0] angle;
        logic [DEC_W:0]     next_cnt;
        scan_report_t       rep;
        if (at_start)
        begin
            // decimation: zero behaves as one, a lowered value examines the next scan
            next_cnt = scan_cnt + 1'b1;
            if (next_cnt[DEC_W-1:0] >= cfg.scan_decimation || next_cnt[DEC_W])
            begin
                scan_cnt = '0;
                examined = 1'b1;
            end
            else
            begin
                scan_cnt = next_cnt[DEC_W-1:0];
                examined = 1'b0;
            end
            hits     = '0;
            angle    = widen_angle(cfg.start_angle);
            at_start = 1'b0;
        end
        else
        begin
            angle = bearing + widen_angle(cfg.angle_step);
            if (angle > BEARING_MAX)
                angle = BEARING_MAX;
            else if (angle < BEARING_MIN)
                angle = BEARING_MIN;
        end
        bearing = angle[ACC_W-1:0];

        // both windows inclusive, an inverted window takes nothing
        if (examined && angle >= widen_angle(cfg.angle_low) &&
            angle <= widen_angle(cfg.angle_high) &&
            range_mm >= cfg.distance_low && range_mm <= cfg.distance_high &&
            hits < MAX_POINTS)
            hits = hits + 1'b1;

        if (last)
        begin
            if (examined)
            begin
                rep.obstacle = (hits > cfg.count_threshold);
                rep.count    = hits;
                expected_reports.push_back(rep);
            end
            hits     = '0;
            at_start = 1'b1;
        end
    endtask

    // watch the port and both streams
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.start_angle     = START_ANGLE_RST;
            cfg.angle_step      = ANGLE_STEP_RST;
            cfg.angle_low       = ANGLE_LOW_RST;
            cfg.angle_high      = ANGLE_HIGH_RST;
            cfg.distance_low    = DISTANCE_LOW_RST;
            cfg.distance_high   = DISTANCE_HIGH_RST;
            cfg.count_threshold = COUNT_THRESHOLD_RST;
            cfg.scan_decimation = SCAN_DECIMATION_RST;
            scan_cnt     = '0;
            examined     = 1'b0;
            at_start     = 1'b1;
            bearing      = '0;
            hits         = '0;
            expected_reports.delete();
            mismatches   = 0;
            outstanding  = 0;
            reports_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr[ADDR_W-1:2], pwdata);

            // report transfer against the oldest prediction
            if (result_valid && result_ready)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report %0d: none expected, got obstacle=%0b count=%0d",
                                 reports_seen, obstacle_present, point_count);
                end
                else
                begin
                    oldest = expected_reports.pop_front();
                    if (obstacle_present !== oldest.obstacle || point_count !== oldest.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"report %0d: expected obstacle=%0b count=%0d, ",
                                      "got obstacle=%0b count=%0d"}, reports_seen,
                                     oldest.obstacle, oldest.count,
                                     obstacle_present, point_count);
                    end
                end
            end

            if (sample_valid && sample_ready)
                track_sample(distance_mm, last_of_scan);

            outstanding = expected_reports.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the scan sector obstacle detector
// drives samples, register writes and report back-pressure; checking sits in scan_report_checker
module tb_top;
    import ssod_pkg::*;

    localparam int RANDOM_SAMPLES = 1650;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int ANGLE_TOP      = 8388607;
    localparam int ANGLE_BOTTOM   = -8388608;
    localparam int DIST_TOP       = 65535;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               sample_valid;
    logic               sample_ready;
    logic [DIST_W-1:0]  distance_mm;
    logic               last_of_scan;
    logic               result_valid;
    logic               result_ready;
    logic               obstacle_present;
    logic [COUNT_W-1:0] point_count;

    int mismatches;
    int outstanding;
    int reports_seen;

    // idle percentages per phase: none, sender, receiver, both
    int idle_table[4]  = '{0, 64, 0, 26};
    int stall_table[4] = '{0, 0, 64, 26};
    int idle_pct;
    int stall_pct;
    int hold_asks;
    int hold_seen;
    int hold_left;
    int samples_sent;
    int settings_used;
    int dist_floor;
    int dist_ceil;

    scan_sector_obstacle_detector dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .distance_mm      (distance_mm),
        .last_of_scan     (last_of_scan),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .obstacle_present (obstacle_present),
        .point_count      (point_count)
    );

    scan_report_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .distance_mm      (distance_mm),
        .last_of_scan     (last_of_scan),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .obstacle_present (obstacle_present),
        .point_count      (point_count),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .reports_seen     (reports_seen)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // report receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // hard limit on run time
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_angle(input int v);
        if (v > ANGLE_TOP)
            return ANGLE_TOP;
        if (v < ANGLE_BOTTOM)
            return ANGLE_BOTTOM;
        return v;
    endfunction

    // distances mostly within or just outside the current window, some anywhere
    function automatic logic [DIST_W-1:0] pick_distance();
        int lo;
        int hi;
        lo = (dist_floor < 3) ? 0 : dist_floor - 3;
        hi = (dist_ceil > DIST_TOP - 3) ? DIST_TOP : dist_ceil + 3;
        case ($urandom_range(0, 9))
            0: return DIST_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return DIST_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic int scan_length();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(25, 300);
        return $urandom_range(1, 24);
    endfunction

    // wait until every report is back and the pipeline has settled
    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // setup then access cycle on the register port
    task automatic apb_write(input ssod_reg_idx_t idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_setting(input int sa, input int st, input int al, input int ah,
                                 input int dl, input int dh, input int th, input int dc);
        drain();
        apb_write(REG_START_ANGLE, sa);
        apb_write(REG_ANGLE_STEP, st);
        apb_write(REG_ANGLE_LOW, al);
        apb_write(REG_ANGLE_HIGH, ah);
        apb_write(REG_DISTANCE_LOW, dl);
        apb_write(REG_DISTANCE_HIGH, dh);
        apb_write(REG_COUNT_THRESHOLD, th);
        apb_write(REG_SCAN_DECIMATION, dc);
        dist_floor = dl;
        dist_ceil  = dh;
        settings_used++;
    endtask

    // one sample transfer, with random idle cycles in front
    task automatic send_sample(input logic [DIST_W-1:0] d, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        distance_mm  <= d;
        last_of_scan <= last;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_scan(input int len);
        for (int i = 0; i < len; i++)
            send_sample(pick_distance(), i == len - 1);
    endtask

    // random register setting, windows placed near the swept angles
    task automatic random_setting();
        int sa;
        int st;
        int al;
        int ah;
        int dl;
        int dh;
        int th;
        int dc;
        int span;
        int tmp;
        case ($urandom_range(0, 7))
            0: sa = ANGLE_BOTTOM;
            1: sa = ANGLE_TOP;
            default: sa = int'($urandom_range(0, 400000)) - 200000;
        endcase
        case ($urandom_range(0, 7))
            0: st = ANGLE_BOTTOM;
            1: st = ANGLE_TOP;
            2: st = 0;
            default: st = int'($urandom_range(0, 6000)) - 3000;
        endcase
        span = (st < 0) ? -st : st;
        if (span > 100000)
            span = 100000;
        al = clamp_angle(sa - 50 + int'($urandom_range(0, 4 * span + 100)));
        ah = clamp_angle(al + int'($urandom_range(0, 20 * span + 100)));
        case ($urandom_range(0, 7))
            0:
            begin
                al = ANGLE_BOTTOM;
                ah = ANGLE_TOP;
            end
            1:
            begin
                // inverted window
                tmp = al;
                al  = ah + 1;
                ah  = tmp;
            end
            default: ;
        endcase
        dl = $urandom_range(0, 2000);
        dh = dl + int'($urandom_range(0, 3000));
        case ($urandom_range(0, 7))
            0:
            begin
                dl = 0;
                dh = DIST_TOP;
            end
            1:
            begin
                dl = DIST_TOP;
                dh = DIST_TOP;
            end
            2: dl = dh + 1;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: th = 0;
            1: th = MAX_POINTS;
            2: th = 8191;
            3: th = $urandom_range(0, 8191);
            default: th = $urandom_range(0, 8);
        endcase
        case ($urandom_range(0, 9))
            0: dc = 0;
            1: dc = 255;
            2: dc = $urandom_range(0, 255);
            default: dc = $urandom_range(1, 3);
        endcase
        write_setting(sa, st, al, ah, dl, dh, th, dc);
    endtask

    initial
    begin
        int random_start;
        int phase;
        int target;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sample_valid = 1'b0;
        distance_mm  = '0;
        last_of_scan = 1'b0;
        result_ready = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_asks    = 0;
        hold_seen    = 0;
        hold_left    = 0;
        dist_floor   = DISTANCE_LOW_RST;
        dist_ceil    = DISTANCE_HIGH_RST;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: first scan skipped, second examined
        send_scan(230);
        send_scan(230);

        // window edges, infinite readings and a one-sample scan
        write_setting(-2, 1, 0, 3, 100, 1000, 2, 1);
        send_sample(16'd500, 1'b0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd99, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd1001, 1'b0);
        send_sample(16'd500, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd500, 1'b1);
        send_sample(16'd500, 1'b1);

        // decimation zero with an inverted angle window
        write_setting(-2, 1, 5, 0, 100, 1000, 0, 0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd500, 1'b1);

        // inverted distance window
        write_setting(0, 0, ANGLE_BOTTOM, ANGLE_TOP, 600, 500, 0, 0);
        send_sample(16'd550, 1'b0);
        send_sample(16'd550, 1'b1);

        // angle accumulator driven into both saturation limits
        write_setting(ANGLE_TOP, ANGLE_TOP, ANGLE_BOTTOM, ANGLE_TOP, 0, DIST_TOP, 0, 1);
        send_scan(520);
        write_setting(ANGLE_BOTTOM, ANGLE_BOTTOM, ANGLE_BOTTOM, ANGLE_TOP, 0, DIST_TOP, 0, 1);
        send_scan(520);

        // point count saturation in one long scan
        write_setting(0, 0, ANGLE_BOTTOM, ANGLE_TOP, 0, DIST_TOP, MAX_POINTS - 1, 1);
        send_scan(MAX_POINTS + 4);

        // largest decimation, then lowered between scans
        write_setting(0, 0, ANGLE_BOTTOM, ANGLE_TOP, 0, DIST_TOP, 0, 255);
        repeat (6)
            send_scan(1);
        write_setting(0, 0, ANGLE_BOTTOM, ANGLE_TOP, 0, DIST_TOP, 0, 2);
        repeat (4)
            send_scan(1);

        // long receiver hold-off while samples keep coming, then pause until all are back
        write_setting(0, 0, ANGLE_BOTTOM, ANGLE_TOP, 0, DIST_TOP, 1, 1);
        hold_asks++;
        repeat (40)
            send_scan($urandom_range(1, 3));
        drain();

        // random settings, cycling through the idle phases
        random_start = samples_sent;
        phase        = 0;
        while (samples_sent - random_start < RANDOM_SAMPLES)
        begin
            random_setting();
            idle_pct  = idle_table[phase % 4];
            stall_pct = stall_table[phase % 4];
            target    = samples_sent + int'($urandom_range(60, 160));
            while (samples_sent < target)
                send_scan(scan_length());
            // sometimes leave a scan open across the next setting
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 5))
                    send_sample(pick_distance(), 1'b0);
            phase++;
        end

        drain();
        $display("Covered %0d samples and %0d scan reports over %0d register settings,",
                 samples_sent, reports_seen, settings_used);
        $display("with window edges, decimation extremes, angle and count saturation");
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ssod_pkg.sv
sv/ssod_regs.sv
sv/ssod_core.sv
sv/scan_sector_obstacle_detector.sv
sv/ssod_checker.sv
verif/scan_report_checker.sv
verif/tb_top.sv
